[rtl/prefix_route_table_assert.svh]
// ----------------------------------------------------------------------------
// Route table assertion macros
// Clocked assertion shorthands used by the route table top level.
// ----------------------------------------------------------------------------
`ifndef PREFIX_ROUTE_TABLE_ASSERT_SVH
`define PREFIX_ROUTE_TABLE_ASSERT_SVH

// check a condition at every clock edge outside reset
`define PRT_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// check an implication within the same cycle
`define PRT_ASSERT_SAME(lbl, trig, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (expr)) else $error(msg);

// check an implication in the next cycle
`define PRT_ASSERT_NEXT(lbl, trig, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) else $error(msg);

`endif

[rtl/prt_pkg.sv]
// ----------------------------------------------------------------------------
// Route table package
// Command and status codes, sequencer states and cell control type.
// ----------------------------------------------------------------------------
package prt_pkg;

  localparam int DEPTH_DEFAULT     = 64;
  localparam int PEER_BITS_DEFAULT = 8;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_EXISTS = 2'd1,
    CMD_ADD    = 2'd2,
    CMD_FLUSH  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  typedef struct packed {
    logic shift;
    logic write;
  } cell_ctrl_t;

endpackage

[rtl/prt_req_if.sv]
// ----------------------------------------------------------------------------
// Route table request channel
// Valid/ready channel carrying one command with its address, mask and peer.
// ----------------------------------------------------------------------------
interface prt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] address;
  logic [31:0] netmask;
  logic [7:0]  peer_id;

  modport source (output valid, output command, output address, output netmask,
                  output peer_id, input ready);
  modport sink   (input valid, input command, input address, input netmask,
                  input peer_id, output ready);
endinterface

[rtl/prt_rsp_if.sv]
// ----------------------------------------------------------------------------
// Route table response channel
// Valid/ready channel carrying one result per command.
// ----------------------------------------------------------------------------
interface prt_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] peer_out;
  logic [6:0] removed_count;

  modport source (output valid, output status, output peer_out,
                  output removed_count, input ready);
  modport sink   (input valid, input status, input peer_out,
                  input removed_count, output ready);
endinterface

[rtl/prt_cell.sv]
// ----------------------------------------------------------------------------
// Route table cell
// One route entry; loads a written entry or its right neighbor on a shift.
// ----------------------------------------------------------------------------
module prt_cell
  import prt_pkg::*;
#(
  parameter int PEER_BITS = PEER_BITS_DEFAULT
) (
  input  logic                 clk,
  input  cell_ctrl_t           ctrl,
  input  logic [31:0]          wr_net,
  input  logic [31:0]          wr_mask,
  input  logic [PEER_BITS-1:0] wr_peer,
  input  logic [31:0]          nb_net,
  input  logic [31:0]          nb_mask,
  input  logic [PEER_BITS-1:0] nb_peer,
  output logic [31:0]          net,
  output logic [31:0]          mask,
  output logic [PEER_BITS-1:0] peer
);

  always_ff @(posedge clk) begin
    if (ctrl.write) begin
      net  <= wr_net;
      mask <= wr_mask;
      peer <= wr_peer;
    end else if (ctrl.shift) begin
      net  <= nb_net;
      mask <= nb_mask;
      peer <= nb_peer;
    end
  end

endmodule

[rtl/prt_seq.sv]
// ----------------------------------------------------------------------------
// Route table sequencer
// Streams the entry queue past the chain head once per command, except for
// an add to a full table, and holds the result register.
// ----------------------------------------------------------------------------
module prt_seq
  import prt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT,
  parameter int PEER_BITS   = PEER_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  prt_req_if.sink                req,
  prt_rsp_if.source              rsp,
  input  logic [31:0]            head_net,
  input  logic [31:0]            head_mask,
  input  logic [PEER_BITS-1:0]   head_peer,
  output logic                   shift,
  output logic [TABLE_DEPTH-1:0] wr_sel,
  output logic [31:0]            wr_net,
  output logic [31:0]            wr_mask,
  output logic [PEER_BITS-1:0]   wr_peer
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  state_t               state, state_next;
  cmd_t                 cmd;
  logic [31:0]          addr;
  logic [31:0]          mask;
  logic [PEER_BITS-1:0] peer;
  logic [CNT_W-1:0]     occ, occ_next;
  logic [CNT_W-1:0]     rem, rem_next;
  logic [CNT_W-1:0]     removed, removed_next;
  logic                 found, found_next;
  logic                 placed, placed_next;
  logic                 full, full_next;
  logic [PEER_BITS-1:0] hit_peer, hit_peer_next;

  logic                 out_valid;
  status_t              out_status;
  logic [7:0]           out_peer;
  logic [6:0]           out_removed;

  status_t              res_status;
  logic [7:0]           res_peer;
  logic                 accept;
  logic                 out_free;
  logic                 finish;
  logic                 rotate;
  logic                 wr_en;
  logic                 wr_rot;
  logic [CNT_W-1:0]     wpos;
  logic [31:0]          masked_addr;
  logic                 lookup_hit;
  logic                 exists_hit;
  logic                 req_full;

  assign req.ready   = (state == S_IDLE);
  assign accept      = req.valid && req.ready;
  assign out_free    = !out_valid || rsp.ready;
  assign masked_addr = addr & mask;
  assign lookup_hit  = ((addr & head_mask) == head_net);
  assign exists_hit  = (head_net == masked_addr) && (head_mask == mask);
  assign req_full    = (cmd_t'(req.command) == CMD_ADD) && (occ == CNT_W'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      occ      <= '0;
      rem      <= '0;
      removed  <= '0;
      found    <= 1'b0;
      placed   <= 1'b0;
      full     <= 1'b0;
      hit_peer <= '0;
    end else begin
      state    <= state_next;
      occ      <= occ_next;
      rem      <= rem_next;
      removed  <= removed_next;
      found    <= found_next;
      placed   <= placed_next;
      full     <= full_next;
      hit_peer <= hit_peer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd  <= cmd_t'(req.command);
      addr <= req.address;
      mask <= req.netmask;
      peer <= PEER_BITS'(req.peer_id);
    end
  end

  always_comb begin
    state_next    = state;
    occ_next      = occ;
    rem_next      = rem;
    removed_next  = removed;
    found_next    = found;
    placed_next   = placed;
    full_next     = full;
    hit_peer_next = hit_peer;
    shift         = 1'b0;
    rotate        = 1'b0;
    wr_en         = 1'b0;
    wr_rot        = 1'b0;
    wpos          = occ;
    finish        = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next   = S_RUN;
          rem_next     = req_full ? '0 : occ;
          removed_next = '0;
          found_next   = 1'b0;
          placed_next  = 1'b0;
          full_next    = req_full;
        end
      end
      S_RUN: begin
        if (rem != '0) begin
          case (cmd)
            CMD_ADD: begin
              if (!placed && (head_mask < mask)) begin
                wr_en       = 1'b1;
                occ_next    = occ + 1'b1;
                placed_next = 1'b1;
              end else begin
                rotate = 1'b1;
              end
            end
            CMD_FLUSH: begin
              if (head_peer == peer) begin
                shift        = 1'b1;
                occ_next     = occ - 1'b1;
                rem_next     = rem - 1'b1;
                removed_next = removed + 1'b1;
              end else begin
                rotate = 1'b1;
              end
            end
            CMD_LOOKUP: begin
              if (!found && lookup_hit) begin
                found_next    = 1'b1;
                hit_peer_next = head_peer;
              end
              rotate = 1'b1;
            end
            CMD_EXISTS: begin
              if (exists_hit) begin
                found_next = 1'b1;
              end
              rotate = 1'b1;
            end
            default: rotate = 1'b1;
          endcase
          if (rotate) begin
            shift    = 1'b1;
            wr_en    = 1'b1;
            wr_rot   = 1'b1;
            wpos     = occ - 1'b1;
            rem_next = rem - 1'b1;
          end
        end else if (out_free) begin
          finish     = 1'b1;
          state_next = S_IDLE;
          if ((cmd == CMD_ADD) && !placed && !full) begin
            wr_en    = 1'b1;
            occ_next = occ + 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      wr_sel[i] = wr_en && (wpos == CNT_W'(i));
    end
  end

  assign wr_net  = wr_rot ? head_net  : masked_addr;
  assign wr_mask = wr_rot ? head_mask : mask;
  assign wr_peer = wr_rot ? head_peer : peer;

  always_comb begin
    res_status = ST_DONE;
    res_peer   = '0;
    case (cmd)
      CMD_LOOKUP: begin
        res_status = found ? ST_DONE : ST_MISS;
        res_peer   = found ? 8'(hit_peer) : '0;
      end
      CMD_EXISTS: res_status = found ? ST_DONE : ST_MISS;
      CMD_ADD:    res_status = full ? ST_FULL : ST_DONE;
      CMD_FLUSH:  res_status = ST_DONE;
      default:    res_status = ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_status  <= res_status;
      out_peer    <= res_peer;
      out_removed <= (cmd == CMD_FLUSH) ? 7'(removed) : '0;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.peer_out      = out_peer;
  assign rsp.removed_count = out_removed;

endmodule

[rtl/prefix_route_table.sv]
// ----------------------------------------------------------------------------
// Longest-prefix route table
// Routes kept in descending mask order in a chain of cells used as a queue.
//
//   channel  dir  fields
//   req      in   command, address, netmask, peer_id
//   rsp      out  status, peer_out, removed_count
//
// The entries pass the head of the cell chain one per cycle, pausing while
// an add inserts its entry, and go back in at the tail unless a flush
// removes them; an add to a full table does not stream them.
// Reset clears the entry count; the cells themselves are not cleared.
// A stalled result is held in the output register; the next command is
// taken meanwhile and waits at its end until the result is taken.
// ----------------------------------------------------------------------------
module prefix_route_table
  import prt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT,
  parameter int PEER_BITS   = PEER_BITS_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  prt_req_if.sink   req,
  prt_rsp_if.source rsp
);

  logic [31:0]          cell_net  [TABLE_DEPTH];
  logic [31:0]          cell_mask [TABLE_DEPTH];
  logic [PEER_BITS-1:0] cell_peer [TABLE_DEPTH];
  cell_ctrl_t           ctrl      [TABLE_DEPTH];

  logic                   shift;
  logic [TABLE_DEPTH-1:0] wr_sel;
  logic [31:0]            wr_net;
  logic [31:0]            wr_mask;
  logic [PEER_BITS-1:0]   wr_peer;

  prt_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PEER_BITS   (PEER_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .head_net  (cell_net[0]),
    .head_mask (cell_mask[0]),
    .head_peer (cell_peer[0]),
    .shift     (shift),
    .wr_sel    (wr_sel),
    .wr_net    (wr_net),
    .wr_mask   (wr_mask),
    .wr_peer   (wr_peer)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam int NB = (i == TABLE_DEPTH - 1) ? 0 : i + 1;

    assign ctrl[i] = '{shift: shift, write: wr_sel[i]};

    prt_cell #(
      .PEER_BITS (PEER_BITS)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl[i]),
      .wr_net  (wr_net),
      .wr_mask (wr_mask),
      .wr_peer (wr_peer),
      .nb_net  (cell_net[NB]),
      .nb_mask (cell_mask[NB]),
      .nb_peer (cell_peer[NB]),
      .net     (cell_net[i]),
      .mask    (cell_mask[i]),
      .peer    (cell_peer[i])
    );
  end

`include "prefix_route_table_assert.svh"

  `PRT_ASSERT_ALWAYS(a_one_write, $onehot0(wr_sel), "more than one cell written")
  `PRT_ASSERT_NEXT(a_ready_drop, req.valid && req.ready, !req.ready, "ready held after transfer")
  `PRT_ASSERT_SAME(a_peer_zero, rsp.valid && (rsp.status != ST_DONE), rsp.peer_out == '0, "peer on miss")
  `PRT_ASSERT_SAME(a_cnt_zero, rsp.valid && (rsp.status != ST_DONE), rsp.removed_count == '0, "count on miss")

endmodule
